[rtl/trb_pkg.sv]
`default_nettype none
package trb_pkg;

   // Field widths.
   localparam int POS_W  = 32;   // Q16.16 position
   localparam int TEX_W  = 20;   // Q4.16 texture coordinate
   localparam int VEC_W  = 48;   // Q32.16 tangent and bitangent components

   // Internal widths.
   localparam int DP_W   = POS_W + 1;       // position delta
   localparam int DT_W   = TEX_W + 1;       // texture delta
   localparam int PROD_W = DP_W + DT_W;     // multiplier product
   localparam int NUM_W  = PROD_W + 1;      // difference of two products
   localparam int DET_W  = 2 * DT_W + 1;    // UV determinant
   localparam int REM_W  = DET_W + 1;       // divider partial remainder
   localparam int FRAC_W = 16;              // fraction bits appended to the dividend
   localparam int LOW_W  = VEC_W - FRAC_W;  // numerator bits shifted in during division
   localparam int HI_W   = NUM_W - LOW_W;   // numerator bits that seed the remainder

   // Vector components: tangent x, y, z then bitangent x, y, z.
   localparam int NUM_COMP = 6;
   localparam int AXES     = 3;
   localparam int COMP_W   = 3;
   localparam int AXIS_W   = 2;

   // Divider: quotient bits retired per cycle and division steps per component.
   localparam int RADIX_BITS = 4;
   localparam int DIV_STEPS  = VEC_W / RADIX_BITS;
   localparam int DCNT_W     = $clog2(DIV_STEPS);

   // Multiplier operand selection.
   localparam logic [1:0] MSEL_DET_A = 2'd0;
   localparam logic [1:0] MSEL_DET_B = 2'd1;
   localparam logic [1:0] MSEL_NUM_A = 2'd2;
   localparam logic [1:0] MSEL_NUM_B = 2'd3;

   typedef struct packed {
      logic              hold0;
      logic              hold1;
      logic              take_last;
      logic [1:0]        mul_sel;
      logic              acc_ld;
      logic              det_ld;
      logic              check;
      logic              div_init;
      logic              div_step;
      logic              store;
      logic [COMP_W-1:0] comp;
   } cmd_type;

endpackage
`default_nettype wire

[rtl/trb_datapath.sv]
`default_nettype none
module trb_datapath
   import trb_pkg::*;
(
   input  wire                     clock,
   input  cmd_type                 cmd,
   input  wire  signed [POS_W-1:0] pos_x,
   input  wire  signed [POS_W-1:0] pos_y,
   input  wire  signed [POS_W-1:0] pos_z,
   input  wire  signed [TEX_W-1:0] tex_u,
   input  wire  signed [TEX_W-1:0] tex_v,
   output logic                    det_zero,
   output logic signed [VEC_W-1:0] tan_x,
   output logic signed [VEC_W-1:0] tan_y,
   output logic signed [VEC_W-1:0] tan_z,
   output logic signed [VEC_W-1:0] bitan_x,
   output logic signed [VEC_W-1:0] bitan_y,
   output logic signed [VEC_W-1:0] bitan_z,
   output logic                    degenerate
);

   logic signed [POS_W-1:0]  p0_ff [AXES];
   logic signed [POS_W-1:0]  p1_ff [AXES];
   logic signed [TEX_W-1:0]  u0_ff, v0_ff, u1_ff, v1_ff;
   logic signed [DP_W-1:0]   d1_ff [AXES];
   logic signed [DP_W-1:0]   d2_ff [AXES];
   logic signed [DT_W-1:0]   du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [POS_W-1:0]  pos_in [AXES];

   logic signed [DP_W-1:0]   mul_a;
   logic signed [DT_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] acc_ff;
   logic signed [NUM_W-1:0]  diff;
   logic        [NUM_W-1:0]  diff_abs;
   logic        [AXIS_W-1:0] axis;
   logic                     is_bitan;

   logic                     det_neg_ff;
   logic        [DET_W-1:0]  ud_ff;
   logic                     neg_ff;
   logic                     ovf_ff;
   logic        [REM_W-1:0]  rem_ff, rem_in;
   logic        [VEC_W-1:0]  dvd_ff, dvd_in;
   logic        [VEC_W-1:0]  quo_ff, quo_in;
   logic signed [VEC_W-1:0]  res;
   logic signed [VEC_W-1:0]  vec_ff [NUM_COMP];
   logic                     degen_ff;

   assign pos_in[0] = pos_x;
   assign pos_in[1] = pos_y;
   assign pos_in[2] = pos_z;

   // Vertex holding and delta capture.
   always_ff @(posedge clock) begin
      if (cmd.hold0) begin
         for (int i = 0; i < AXES; i++) p0_ff[i] <= pos_in[i];
         u0_ff <= tex_u;
         v0_ff <= tex_v;
      end
      if (cmd.hold1) begin
         for (int i = 0; i < AXES; i++) p1_ff[i] <= pos_in[i];
         u1_ff <= tex_u;
         v1_ff <= tex_v;
      end
      if (cmd.take_last) begin
         for (int i = 0; i < AXES; i++) begin
            d1_ff[i] <= DP_W'(p1_ff[i]) - DP_W'(p0_ff[i]);
            d2_ff[i] <= DP_W'(pos_in[i]) - DP_W'(p0_ff[i]);
         end
         du1_ff <= DT_W'(u1_ff) - DT_W'(u0_ff);
         dv1_ff <= DT_W'(v1_ff) - DT_W'(v0_ff);
         du2_ff <= DT_W'(tex_u) - DT_W'(u0_ff);
         dv2_ff <= DT_W'(tex_v) - DT_W'(v0_ff);
      end
   end

   // Operand selection for the shared multiplier.
   assign is_bitan = (cmd.comp >= COMP_W'(AXES));
   assign axis     = is_bitan ? AXIS_W'(cmd.comp - COMP_W'(AXES)) : AXIS_W'(cmd.comp);

   always_comb begin
      case (cmd.mul_sel)
         MSEL_DET_A: begin
            mul_a = DP_W'(du1_ff);
            mul_b = dv2_ff;
         end
         MSEL_DET_B: begin
            mul_a = DP_W'(dv1_ff);
            mul_b = du2_ff;
         end
         MSEL_NUM_A: begin
            mul_a = is_bitan ? d2_ff[axis] : d1_ff[axis];
            mul_b = is_bitan ? du1_ff : dv2_ff;
         end
         MSEL_NUM_B: begin
            mul_a = is_bitan ? d1_ff[axis] : d2_ff[axis];
            mul_b = is_bitan ? du2_ff : dv1_ff;
         end
         default: begin
            mul_a = DP_W'(du1_ff);
            mul_b = dv2_ff;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign diff     = NUM_W'(acc_ff) - NUM_W'(prod_ff);
   assign diff_abs = diff[NUM_W-1] ? NUM_W'(-diff) : NUM_W'(diff);
   assign det_zero = (ud_ff == '0);

   // Radix 16 restoring division: four quotient bits a cycle.
   always_comb begin
      logic [REM_W-1:0] r;
      logic [VEC_W-1:0] d;
      logic [VEC_W-1:0] q;
      r = rem_ff;
      d = dvd_ff;
      q = quo_ff;
      for (int k = 0; k < RADIX_BITS; k++) begin
         r = {r[REM_W-2:0], d[VEC_W-1]};
         d = {d[VEC_W-2:0], 1'b0};
         if (r >= REM_W'(ud_ff)) begin
            r = r - REM_W'(ud_ff);
            q = {q[VEC_W-2:0], 1'b1};
         end else begin
            q = {q[VEC_W-2:0], 1'b0};
         end
      end
      rem_in = r;
      dvd_in = d;
      quo_in = q;
   end

   // Sign and saturation of the finished quotient.
   always_comb begin
      if (neg_ff) begin
         if (ovf_ff || quo_ff[VEC_W-1]) res = {1'b1, {(VEC_W-1){1'b0}}};
         else                           res = -$signed(quo_ff);
      end else begin
         if (ovf_ff || quo_ff[VEC_W-1]) res = {1'b0, {(VEC_W-1){1'b1}}};
         else                           res = $signed(quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.acc_ld) acc_ff <= prod_ff;
      if (cmd.det_ld) begin
         det_neg_ff <= diff[NUM_W-1];
         ud_ff      <= diff_abs[DET_W-1:0];
      end
      if (cmd.div_init) begin
         neg_ff <= diff[NUM_W-1] ^ det_neg_ff;
         ovf_ff <= (DET_W'(diff_abs[NUM_W-1:LOW_W]) >= ud_ff);
         rem_ff <= REM_W'(diff_abs[NUM_W-1:LOW_W]);
         dvd_ff <= {diff_abs[LOW_W-1:0], {FRAC_W{1'b0}}};
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
         quo_ff <= quo_in;
      end
      if (cmd.check) begin
         degen_ff <= det_zero;
         if (det_zero) begin
            for (int i = 0; i < NUM_COMP; i++) vec_ff[i] <= '0;
         end
      end
      if (cmd.store) vec_ff[cmd.comp] <= res;
   end

   assign tan_x      = vec_ff[0];
   assign tan_y      = vec_ff[1];
   assign tan_z      = vec_ff[2];
   assign bitan_x    = vec_ff[3];
   assign bitan_y    = vec_ff[4];
   assign bitan_z    = vec_ff[5];
   assign degenerate = degen_ff;

endmodule
`default_nettype wire

[rtl/trb_control.sv]
`default_nettype none
module trb_control
   import trb_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  wire     rsp_stall,
   input  wire     det_zero,
   output cmd_type cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DET0  = 4'd1;
   localparam logic [3:0] ST_DET1  = 4'd2;
   localparam logic [3:0] ST_DET2  = 4'd3;
   localparam logic [3:0] ST_CHK   = 4'd4;
   localparam logic [3:0] ST_N0    = 4'd5;
   localparam logic [3:0] ST_N1    = 4'd6;
   localparam logic [3:0] ST_N2    = 4'd7;
   localparam logic [3:0] ST_DIV   = 4'd8;
   localparam logic [3:0] ST_STORE = 4'd9;

   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;

   logic [3:0]        state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [COMP_W-1:0] comp_ff, comp_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              finish;

   assign req_stall = (state_ff != ST_IDLE) || ((phase_ff == PH_THIRD) && rsp_valid_ff);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      comp_in      = comp_ff;
      dcnt_in      = dcnt_ff;
      finish       = 1'b0;
      cmd          = '0;
      cmd.comp     = comp_ff;
      cmd.mul_sel  = MSEL_DET_A;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (phase_ff)
                  PH_SECOND: begin
                     cmd.hold1 = 1'b1;
                     phase_in  = PH_THIRD;
                  end
                  PH_THIRD: begin
                     cmd.take_last = 1'b1;
                     phase_in      = PH_FIRST;
                     state_in      = ST_DET0;
                  end
                  default: begin
                     cmd.hold0 = 1'b1;
                     phase_in  = PH_SECOND;
                  end
               endcase
            end
         end
         ST_DET0: begin
            cmd.mul_sel = MSEL_DET_A;
            state_in    = ST_DET1;
         end
         ST_DET1: begin
            cmd.mul_sel = MSEL_DET_B;
            cmd.acc_ld  = 1'b1;
            state_in    = ST_DET2;
         end
         ST_DET2: begin
            cmd.det_ld = 1'b1;
            state_in   = ST_CHK;
         end
         ST_CHK: begin
            cmd.check = 1'b1;
            comp_in   = '0;
            if (det_zero) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_N0;
            end
         end
         ST_N0: begin
            cmd.mul_sel = MSEL_NUM_A;
            state_in    = ST_N1;
         end
         ST_N1: begin
            cmd.mul_sel = MSEL_NUM_B;
            cmd.acc_ld  = 1'b1;
            state_in    = ST_N2;
         end
         ST_N2: begin
            cmd.div_init = 1'b1;
            dcnt_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (comp_ff == COMP_W'(NUM_COMP - 1)) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = ST_N0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish)                       rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      else                              rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FIRST;
         rsp_valid_ff <= 1'b0;
         comp_ff      <= '0;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         comp_ff      <= comp_in;
         dcnt_ff      <= dcnt_in;
      end
   end

   // Vertices are taken only while the datapath is free.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == ST_IDLE))
      else $error("vertex accepted while a triangle is in progress");

   // A triangle never starts while its predecessor's result is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == PH_THIRD)) |-> !rsp_valid_ff)
      else $error("third vertex accepted over a pending result");

   // A result appears only at the end of a triangle.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_CHK)
         || (($past(state_ff) == ST_STORE) && ($past(comp_ff) == COMP_W'(NUM_COMP - 1))))
      else $error("result raised outside the end of a triangle");

   // The division counter stays within its sweep.
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dcnt_ff < DCNT_W'(DIV_STEPS)))
      else $error("division step counter out of range");

endmodule
`default_nettype wire

[rtl/triangle_tangent_basis.sv]
// Triangle tangent and bitangent unit.
// The req_ channel carries one vertex per item (Q16.16 position, Q4.16 texture
// coordinate), three items per triangle. The first two vertices are only held
// and give no result; the third starts the computation, and one rsp_ item with
// the Q32.16 tangent, the bitangent and the degenerate flag follows for it.
// After the third vertex, one shared 33x21 multiplier forms the UV determinant in
// the states DET0, DET1 and DET2, and the CHK state then checks it for zero. Each
// of the six components then passes through the multiplier states N0, N1 and N2,
// the radix-16 divider steps and one store state; the result is shown after the
// store of the last component, or after the check if the determinant is zero.
// The divider steps take most of the time per triangle.
// The result sits in an output register; the first two vertices of the next
// triangle may be taken while it waits, and its third vertex is stalled until
// the pending result has been taken. req_stall is also high throughout the
// computation. A stalled result holds its value. Synchronous reset empties the
// output and restarts at the first vertex of a triangle.
`default_nettype none
module triangle_tangent_basis
   import trb_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire  signed [POS_W-1:0] req_pos_x,
   input  wire  signed [POS_W-1:0] req_pos_y,
   input  wire  signed [POS_W-1:0] req_pos_z,
   input  wire  signed [TEX_W-1:0] req_tex_u,
   input  wire  signed [TEX_W-1:0] req_tex_v,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic signed [VEC_W-1:0] rsp_tan_x,
   output logic signed [VEC_W-1:0] rsp_tan_y,
   output logic signed [VEC_W-1:0] rsp_tan_z,
   output logic signed [VEC_W-1:0] rsp_bitan_x,
   output logic signed [VEC_W-1:0] rsp_bitan_y,
   output logic signed [VEC_W-1:0] rsp_bitan_z,
   output logic                    rsp_degenerate
);

   // Command bundle from the sequencer and the zero-determinant status back.
   cmd_type cmd;
   logic    det_zero;

   // The controller owns the vertex phase, the handshakes and the step order.
   trb_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .det_zero  (det_zero),
      .cmd       (cmd)
   );

   // The datapath holds the vertices, the multiplier, the divider and the
   // output registers.
   trb_datapath u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .pos_x      (req_pos_x),
      .pos_y      (req_pos_y),
      .pos_z      (req_pos_z),
      .tex_u      (req_tex_u),
      .tex_v      (req_tex_v),
      .det_zero   (det_zero),
      .tan_x      (rsp_tan_x),
      .tan_y      (rsp_tan_y),
      .tan_z      (rsp_tan_z),
      .bitan_x    (rsp_bitan_x),
      .bitan_y    (rsp_bitan_y),
      .bitan_z    (rsp_bitan_z),
      .degenerate (rsp_degenerate)
   );

endmodule
`default_nettype wire
